>>> hw/rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg
// Shared codes and types for the ordered list engine.
// ----------------------------------------------------------------------------
package olst_pkg;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;

	// what every cell does at each clock edge
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PREPEND,
		OP_APPEND,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		value_t   value;
	} cell_ctl_t;

endpackage

>>> hw/rtl/olst_in_if.sv
// ----------------------------------------------------------------------------
// olst_in_if
// Command channel of the ordered list engine: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface olst_in_if;
	logic                          valid;
	logic                          ready;
	logic [olst_pkg::CMD_W-1:0]    command;
	logic signed [olst_pkg::VALUE_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

>>> hw/rtl/olst_out_if.sv
// ----------------------------------------------------------------------------
// olst_out_if
// Result channel of the ordered list engine: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface olst_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [olst_pkg::VALUE_W-1:0] entry_value;
	logic                                last;
	logic [olst_pkg::STATUS_W-1:0]       status;
	logic [olst_pkg::COUNT_W-1:0]        entry_count;

	modport source (output valid, output entry_value, output last, output status,
		output entry_count, input ready);
	modport sink (input valid, input entry_value, input last, input status,
		input entry_count, output ready);
endinterface

>>> hw/rtl/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell
// One list slot: holds an entry and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module olst_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 5
) (
	input  logic                clk,
	input  olst_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]    count,
	input  olst_pkg::value_t    left_val,
	input  olst_pkg::value_t    right_val,
	input  olst_pkg::value_t    head_val,
	input  logic                match_in,
	output logic                match_out,
	output olst_pkg::value_t    val
);
	import olst_pkg::*;

	value_t val_q;
	logic   occ;
	logic   at_tail;
	logic   hit;

	assign occ       = CNT_W'(CELL_IDX) < count;
	assign at_tail   = CNT_W'(CELL_IDX + 1) == count;
	assign hit       = occ && (val_q == ctl.value);
	// high from the first matching slot onward
	assign match_out = match_in | hit;
	assign val       = val_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_PREPEND: begin
				val_q <= (CELL_IDX == 0) ? ctl.value : left_val;
			end
			OP_APPEND: begin
				if (CNT_W'(CELL_IDX) == count) begin
					val_q <= ctl.value;
				end
			end
			OP_DELETE: begin
				if (match_out && occ) begin
					val_q <= right_val;
				end
			end
			OP_ROTATE: begin
				// tail takes the head so the list comes back after count steps
				if (at_tail) begin
					val_q <= head_val;
				end else if (occ) begin
					val_q <= right_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

>>> hw/rtl/ordered_list_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded ordered list of signed 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// usage:
//   req carries one command word (prepend, append, delete first match, clear,
//   read out) with a value; rsp returns result words through an output
//   register. a word moves when valid and ready are both high.
//   prepend, append, delete, clear and unused codes finish in the cycle they
//   are taken: the cells update at once and the single status word shows on rsp
//   the next cycle, so these commands go at one per cycle while rsp keeps up.
//   a read out of n entries rotates the cell chain one slot per cycle and sends
//   one word per cycle while rsp keeps up, front first. acceptance sets the
//   busy flag, after which the output register takes each entry from the head
//   cell; req is held off until the last entry is loaded. a read of an empty
//   list gives one empty status word like the other commands.
//   req.ready is low while rsp holds a word that is not taken, so a stalled
//   receiver freezes the block with no word lost.
//   reset empties the list and drops any pending word; entry contents are not
//   cleared and are never shown before they are written.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	olst_in_if.sink    req,
	olst_out_if.source rsp
);
	import olst_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_idx_q;
	logic          busy_q;

	logic                  out_valid_q;
	value_t                out_value_q;
	logic                  out_last_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [COUNT_W-1:0]    out_count_q;

	cell_ctl_t           ctl;
	value_t              vals [MAX_ENTRIES];
	logic [MAX_ENTRIES:0] match;

	logic                out_free;
	logic                accept;
	logic                full;
	logic                found;
	logic                rd_last;
	logic [CW-1:0]       cnt_next;
	logic [STATUS_W-1:0] status_next;
	logic [CW+4:0]       cnt_ext;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = !busy_q && out_free;
	assign accept    = req.valid && req.ready;
	assign full      = cnt_q == CW'(MAX_ENTRIES);
	assign found     = match[MAX_ENTRIES];
	assign rd_last   = rd_idx_q == (cnt_q - CW'(1));

	// status and new count for single-word commands
	always_comb begin
		cnt_next    = cnt_q;
		status_next = ST_OK;
		unique case (req.command) inside
			CMD_PREPEND, CMD_APPEND: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					cnt_next = cnt_q + CW'(1);
				end
			end
			CMD_DELETE: begin
				if (found) begin
					cnt_next = cnt_q - CW'(1);
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			CMD_CLEAR: begin
				cnt_next = '0;
			end
			CMD_READ: begin
				status_next = ST_EMPTY;
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	always_comb begin
		ctl.value = req.value;
		ctl.op    = OP_HOLD;
		if (busy_q) begin
			if (out_free) begin
				ctl.op = OP_ROTATE;
			end
		end else if (accept) begin
			unique case (req.command)
				CMD_PREPEND: ctl.op = full ? OP_HOLD : OP_PREPEND;
				CMD_APPEND:  ctl.op = full ? OP_HOLD : OP_APPEND;
				CMD_DELETE:  ctl.op = OP_DELETE;
				default:     ctl.op = OP_HOLD;
			endcase
		end
	end

	assign match[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		olst_cell #(
			.CELL_IDX (i),
			.CNT_W    (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (cnt_q),
			.left_val  ((i == 0) ? req.value : vals[(i == 0) ? 0 : i - 1]),
			.right_val (vals[(i == MAX_ENTRIES - 1) ? i : i + 1]),
			.head_val  (vals[0]),
			.match_in  (match[i]),
			.match_out (match[i+1]),
			.val       (vals[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
					rd_idx_q    <= rd_idx_q + CW'(1);
					if (rd_last) begin
						busy_q <= 1'b0;
					end
				end
			end else if (accept) begin
				if (req.command == CMD_READ && cnt_q != '0) begin
					busy_q      <= 1'b1;
					rd_idx_q    <= '0;
					out_valid_q <= 1'b0;
				end else begin
					cnt_q       <= cnt_next;
					out_valid_q <= 1'b1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cnt_ext = {5'b0, (busy_q ? cnt_q : cnt_next)};

	always_ff @(posedge clk) begin
		if (busy_q && out_free) begin
			out_value_q  <= vals[0];
			out_last_q   <= rd_last;
			out_status_q <= ST_OK;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
		end else if (accept) begin
			out_value_q  <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= status_next;
			out_count_q  <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.last        = out_last_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready)
		else $error("command taken during read out");

	a_busy_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(accept && req.command == CMD_READ))
		else $error("read out started without a read command");

	a_cnt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && $past(busy_q) |-> $stable(cnt_q))
		else $error("entry count changed during read out");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rd_idx_q < cnt_q)
		else $error("read index past list end");
`endif

endmodule

>>> tb/ordered_list_engine_top_test.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_top_test
// Self-checking bench for the ordered list engine. A short table of commands
// covers the empty, full and not-found paths, the value extremes and a
// spare command code. About 150 random commands follow in three idling
// phases, with a shadow list that predicts every result word.
// ----------------------------------------------------------------------------
module ordered_list_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import olst_pkg::*;

	localparam int                LIST_DEPTH    = 16;
	localparam int                QUIET_LIMIT   = 2000;
	localparam int                DRAIN_CYCLES  = 24;
	localparam int                PHASE_ITEMS   = 50;
	localparam logic [CMD_W-1:0]  CMD_LAST_CODE = 3'd7;
	localparam value_t            VALUE_MIN     = 32'sh8000_0000;
	localparam value_t            VALUE_MAX     = 32'sh7fff_ffff;

	typedef struct packed {
		value_t                entry_value;
		logic                  last;
		logic [STATUS_W-1:0]   status;
		logic [COUNT_W-1:0]    entry_count;
	} list_result_t;

	typedef struct {
		logic [CMD_W-1:0]    cmd;
		value_t              value;
		int                  reps;
		bit                  typed;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} cmd_row_t;

	logic clk;
	logic arst_n;

	olst_in_if  req_if ();
	olst_out_if rsp_if ();

	ordered_list_engine_top #(
		.MAX_ENTRIES(LIST_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	value_t       shadow_list[$];
	list_result_t step_results[$];
	list_result_t awaited_results[$];
	int           failures = 0;
	int           send_idle_pct = 10;
	int           recv_stall_pct = 62;
	int           quiet_cycles = 0;
	bit           growing = 1'b1;

	// value 100 row is repeated with values 100 + k % 5, so duplicates exist
	cmd_row_t cmd_table [17] = '{
		'{CMD_READ,      -7,         1, 1'b1, ST_EMPTY,     5'd0},
		'{CMD_DELETE,    5,          1, 1'b1, ST_NOT_FOUND, 5'd0},
		'{CMD_PREPEND,   VALUE_MAX,  1, 1'b1, ST_OK,        5'd1},
		'{CMD_APPEND,    VALUE_MIN,  1, 1'b1, ST_OK,        5'd2},
		'{CMD_PREPEND,   -1,         1, 1'b0, ST_OK,        5'd0},
		'{CMD_READ,      VALUE_MAX,  1, 1'b0, ST_OK,        5'd0},
		'{CMD_DELETE,    VALUE_MAX,  1, 1'b0, ST_OK,        5'd0},
		'{CMD_DELETE,    12345,      1, 1'b1, ST_NOT_FOUND, 5'd2},
		'{CMD_LAST_CODE, 32'sh55aa,  1, 1'b1, ST_OK,        5'd2},
		'{CMD_CLEAR,     VALUE_MIN,  1, 1'b1, ST_OK,        5'd0},
		'{CMD_APPEND,    100,        16, 1'b0, ST_OK,       5'd0},
		'{CMD_PREPEND,   7,          1, 1'b1, ST_FULL,      5'd16},
		'{CMD_APPEND,    VALUE_MIN,  1, 1'b1, ST_FULL,      5'd16},
		'{CMD_READ,      0,          1, 1'b0, ST_OK,        5'd0},
		'{CMD_DELETE,    102,        1, 1'b0, ST_OK,        5'd0},
		'{CMD_READ,      -1,         1, 1'b0, ST_OK,        5'd0},
		'{CMD_CLEAR,     0,          1, 1'b1, ST_OK,        5'd0}
	};

	always #1 clk = ~clk;

	// shadow list: update it and leave the words this command produces
	function automatic void apply_command(input logic [CMD_W-1:0] cmd, input value_t val);
		int                  hit;
		logic [STATUS_W-1:0] st;
		hit = -1;
		st  = ST_OK;
		step_results.delete();
		case (cmd) inside
			CMD_PREPEND, CMD_APPEND: begin
				if (shadow_list.size() >= LIST_DEPTH)
					st = ST_FULL;
				else if (cmd == CMD_PREPEND)
					shadow_list.push_front(val);
				else
					shadow_list.push_back(val);
			end
			CMD_DELETE: begin
				foreach (shadow_list[i])
					if (hit < 0 && shadow_list[i] == val)
						hit = i;
				if (hit < 0)
					st = ST_NOT_FOUND;
				else
					shadow_list.delete(hit);
			end
			CMD_CLEAR: begin
				shadow_list.delete();
			end
			CMD_READ: begin
				if (shadow_list.size() == 0) begin
					st = ST_EMPTY;
				end else begin
					foreach (shadow_list[i])
						step_results.push_back('{shadow_list[i],
							i == shadow_list.size() - 1, ST_OK,
							COUNT_W'(shadow_list.size())});
					return;
				end
			end
			default: begin
			end
		endcase
		step_results.push_back('{'0, 1'b1, st, COUNT_W'(shadow_list.size())});
	endfunction

	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		if (shadow_list.size() >= LIST_DEPTH)
			growing = 1'b0;
		else if (shadow_list.size() == 0)
			growing = 1'b1;
		else if ($urandom_range(14) == 0)
			growing = !growing;
		r = $urandom_range(99);
		if (growing) begin
			if (r < 38) return CMD_PREPEND;
			if (r < 75) return CMD_APPEND;
			if (r < 85) return CMD_DELETE;
			if (r < 93) return CMD_READ;
			if (r < 95) return CMD_CLEAR;
		end else begin
			if (r < 10) return CMD_PREPEND;
			if (r < 20) return CMD_APPEND;
			if (r < 72) return CMD_DELETE;
			if (r < 87) return CMD_READ;
			if (r < 92) return CMD_CLEAR;
		end
		return CMD_W'($urandom_range(int'(CMD_LAST_CODE), int'(CMD_READ) + 1));
	endfunction

	function automatic value_t pick_value(input logic [CMD_W-1:0] cmd);
		int r;
		r = $urandom_range(9);
		// deletes mostly aim at something that is really in the list
		if (cmd == CMD_DELETE && shadow_list.size() != 0 && r < 7)
			return shadow_list[$urandom_range(shadow_list.size() - 1)];
		if (r < 4)
			return value_t'($urandom_range(7)) - 4;
		if (r == 4) begin
			case ($urandom_range(3))
				0: return VALUE_MIN;
				1: return VALUE_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		return value_t'($urandom);
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_command(input logic [CMD_W-1:0] cmd, input value_t val,
		input bit typed, input logic [STATUS_W-1:0] t_status,
		input logic [COUNT_W-1:0] t_count);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.command <= cmd;
		req_if.value   <= val;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		apply_command(cmd, val);
		if (typed)
			awaited_results.push_back('{'0, 1'b1, t_status, t_count});
		else
			foreach (step_results[i])
				awaited_results.push_back(step_results[i]);
		@(negedge clk);
	endtask

	task automatic hold_until_answered();
		req_if.valid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n)
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result word with nothing pending: value %0d status %0d",
					rsp_if.entry_value, rsp_if.status);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				if (rsp_if.entry_value !== want.entry_value) begin
					$error("entry_value: expected %0d, got %0d", want.entry_value,
						rsp_if.entry_value);
					failures++;
				end
				if (rsp_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_if.last);
					failures++;
				end
				if (rsp_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_if.status);
					failures++;
				end
				if (rsp_if.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp_if.entry_count);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles where no word moves on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.command = CMD_PREPEND;
		req_if.value   = '0;
		rsp_if.ready   = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (cmd_table[r])
			for (int k = 0; k < cmd_table[r].reps; k++)
				send_command(cmd_table[r].cmd, cmd_table[r].value + k % 5,
					cmd_table[r].typed, cmd_table[r].status, cmd_table[r].count);
		hold_until_answered();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 10;
					recv_stall_pct = 62;
				end
				1: begin
					send_idle_pct  = 62;
					recv_stall_pct = 10;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				cmd = pick_command();
				send_command(cmd, pick_value(cmd), 1'b0, ST_OK, '0);
			end
			hold_until_answered();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d result words never arrived", awaited_results.size());
			failures++;
		end
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
